@@ rtl/pfa_pkg.sv @@
// Shared types and constants for the page frame assigner.
// Used by every module of the block but pfa_ram; depends on nothing.
package pfa_pkg;

    // Default sizes of the frame map and of one allocation.
    localparam int MAX_FRAMES_DEF = 256;
    localparam int MAX_PAGES_DEF  = 64;

    // Fixed field widths of the block's ports.
    localparam int PAGE_SIZE_W   = 16;
    localparam int FRAME_COUNT_W = 9;
    localparam int FRAME_IDX_W   = 8;
    localparam int PROC_SIZE_W   = 14;
    localparam int PAGE_NUM_W    = 7;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 1;

    // Smallest page size, the first frame that may be assigned, and the frame count limits.
    localparam logic [PAGE_SIZE_W-1:0]   MIN_PAGE_SIZE   = 16'd128;
    localparam logic [FRAME_COUNT_W-1:0] FIRST_FRAME     = 9'd3;
    localparam logic [FRAME_COUNT_W-1:0] MIN_FRAME_COUNT = 9'd4;
    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 9'd256;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_SIZE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT = 1'b1;

    // Word kinds.
    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    // Number of commands held between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic                   kind;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   frame_used;
    } pfa_cmd_t;

endpackage

@@ rtl/pfa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pfa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pfa_front.sv @@
// Front part: accepts input words, computes the page count of an allocation
// with a serial divider, and pushes classified commands. Depends on pfa_pkg.
module pfa_front
    import pfa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    localparam int PG_W = $clog2(MAX_PAGES + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [FRAME_IDX_W-1:0] frame_index,
    input  logic                   frame_used,
    input  logic [PROC_SIZE_W-1:0] process_size,
    input  logic [PAGE_SIZE_W-1:0] page_size,
    input  logic                   q_full,
    output logic                   push,
    output pfa_cmd_t               push_cmd,
    output logic [PG_W-1:0]        push_pages
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    localparam int STEP_W = $clog2(PROC_SIZE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROC_SIZE_W - 1);

    front_state_t            state_reg, state_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [PROC_SIZE_W-1:0]  dq_reg, dq_next;
    logic [PAGE_SIZE_W-1:0]  rem_reg, rem_next;
    logic [PAGE_SIZE_W-1:0]  eff_page;
    logic [PAGE_SIZE_W:0]    rem_shift;
    logic                    fits;
    logic [PROC_SIZE_W:0]    raw_pages;
    logic [PG_W-1:0]         sat_pages;
    logic                    accept;

    // Pages are never smaller than the minimum page size.
    assign eff_page = (page_size < MIN_PAGE_SIZE) ? MIN_PAGE_SIZE : page_size;

    // One restoring division step per cycle.
    assign rem_shift = {rem_reg, dq_reg[PROC_SIZE_W-1]};
    assign fits      = rem_shift >= {1'b0, eff_page};

    // Page count rounded up and limited to one allocation's worth.
    assign raw_pages = {1'b0, dq_reg} + {{PROC_SIZE_W{1'b0}}, (rem_reg != '0)};
    always_comb
    begin
        if (32'(raw_pages) > MAX_PAGES)
        begin
            sat_pages = PG_W'(MAX_PAGES);
        end
        else
        begin
            sat_pages = PG_W'(raw_pages);
        end
    end

    assign in_stall = (state_reg != F_IDLE) || q_full;
    assign accept   = in_valid && !in_stall;

    // Map words go straight to the queue; allocations after the division.
    always_comb
    begin
        push_cmd.kind        = kind;
        push_cmd.frame_index = frame_index;
        push_cmd.frame_used  = frame_used;
        push_pages           = '0;
        push                 = 1'b0;
        if (state_reg == F_PUSH)
        begin
            push_cmd.kind = KIND_ALLOC;
            push_pages    = sat_pages;
            push          = (raw_pages != '0) && !q_full;
        end
        else if (accept && (kind == KIND_MAP))
        begin
            push = 1'b1;
        end
    end

    // Sequencer for the divider.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && (kind == KIND_ALLOC))
                begin
                    dq_next    = process_size;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                dq_next   = {dq_reg[PROC_SIZE_W-2:0], fits};
                rem_next  = fits ? PAGE_SIZE_W'(rem_shift - {1'b0, eff_page})
                                 : PAGE_SIZE_W'(rem_shift);
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                // An empty process produces no command at all.
                if ((raw_pages == '0) || !q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

endmodule

@@ rtl/pfa_queue.sv @@
// Short command queue between the front and back parts.
// Depends on pfa_pkg for its depth.
module pfa_queue
    import pfa_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (32'(count_reg) == QUEUE_DEPTH);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (32'(wptr_reg) == QUEUE_DEPTH - 1) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (32'(rptr_reg) == QUEUE_DEPTH - 1) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/pfa_back.sv @@
// Back part: holds the frame map, scans it for free frames, falls back to
// round-robin sharing, and drives the output word. Depends on pfa_pkg, pfa_ram.
module pfa_back
    import pfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    localparam int PG_W = $clog2(MAX_PAGES + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [FRAME_COUNT_W-1:0] frame_count,
    input  logic                     q_not_empty,
    input  pfa_cmd_t                 q_cmd,
    input  logic [PG_W-1:0]          q_pages,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [PAGE_NUM_W-1:0]    page_number,
    output logic [FRAME_IDX_W-1:0]   frame_number,
    output logic                     last
);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_READ  = 4'b0010,
        B_CHECK = 4'b0100,
        B_WRAP  = 4'b1000
    } back_state_t;

    // Only frames below MAP_DEPTH (at most 256) can be loaded; the rest always read as free.
    localparam int MAP_DEPTH = (MAX_FRAMES > 256) ? 256 : MAX_FRAMES;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int MAX_FC    = (MAX_FRAMES > 511) ? 511 : MAX_FRAMES;

    back_state_t              state_reg, state_next;
    logic [FRAME_COUNT_W-1:0] frame_reg, frame_next;
    logic [PG_W-1:0]          placed_reg, placed_next;
    logic [PG_W-1:0]          pages_reg, pages_next;
    logic [MAP_DEPTH-1:0]     map_vld_reg;
    logic                     vld_rd_reg;
    logic                     out_valid_reg;
    logic [PAGE_NUM_W-1:0]    out_page_reg;
    logic [FRAME_IDX_W-1:0]   out_frame_reg;
    logic                     out_last_reg;

    logic [FRAME_COUNT_W-1:0] fc_eff;
    logic [FRAME_COUNT_W-1:0] frame_inc;
    logic [31:0]              page_num_full;
    logic                     is_last;
    logic                     out_free;
    logic                     emit;
    logic                     map_we;
    logic                     rd_en;
    logic                     in_map;
    logic [0:0]               rd_data;
    logic                     frame_busy;

    // Frame count limited to the range MIN_FRAME_COUNT to MAX_FC.
    always_comb
    begin
        if (frame_count < MIN_FRAME_COUNT)
        begin
            fc_eff = MIN_FRAME_COUNT;
        end
        else if (32'(frame_count) > MAX_FC)
        begin
            fc_eff = FRAME_COUNT_W'(MAX_FC);
        end
        else
        begin
            fc_eff = frame_count;
        end
    end

    assign frame_inc     = frame_reg + 1'b1;
    assign page_num_full = 32'(placed_reg) + 32'd1;
    assign is_last       = (page_num_full == 32'(pages_reg));
    assign out_free      = !out_valid_reg || !out_stall;
    assign in_map        = (32'(frame_reg) < MAP_DEPTH);
    assign frame_busy    = rd_data[0] && vld_rd_reg;

    // Map loads are carried out as soon as they leave the queue.
    assign q_pop  = (state_reg == B_IDLE) && q_not_empty;
    assign map_we = q_pop && (q_cmd.kind == KIND_MAP)
                    && (32'(q_cmd.frame_index) < MAP_DEPTH);
    assign rd_en  = (state_reg == B_READ) && (frame_reg < fc_eff);

    pfa_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (q_cmd.frame_index[MAP_AW-1:0]),
        .wdata (q_cmd.frame_used),
        .re    (rd_en),
        .raddr (frame_reg[MAP_AW-1:0]),
        .rdata (rd_data)
    );

    // Allocation sequencer: free-frame scan, then round-robin fill.
    always_comb
    begin
        state_next  = state_reg;
        frame_next  = frame_reg;
        placed_next = placed_reg;
        pages_next  = pages_reg;
        emit        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop && (q_cmd.kind == KIND_ALLOC))
                begin
                    pages_next  = q_pages;
                    placed_next = '0;
                    frame_next  = FIRST_FRAME;
                    state_next  = B_READ;
                end
            end
            B_READ:
            begin
                if (frame_reg < fc_eff)
                begin
                    state_next = B_CHECK;
                end
                else
                begin
                    frame_next = FIRST_FRAME;
                    state_next = B_WRAP;
                end
            end
            B_CHECK:
            begin
                if (frame_busy)
                begin
                    frame_next = frame_inc;
                    state_next = B_READ;
                end
                else if (out_free)
                begin
                    emit        = 1'b1;
                    placed_next = placed_reg + 1'b1;
                    frame_next  = frame_inc;
                    state_next  = is_last ? B_IDLE : B_READ;
                end
            end
            B_WRAP:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    placed_next = placed_reg + 1'b1;
                    frame_next  = (frame_inc >= fc_eff) ? FIRST_FRAME : frame_inc;
                    if (is_last)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state, map valid bits and the output word's valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            map_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (map_we)
            begin
                map_vld_reg[q_cmd.frame_index[MAP_AW-1:0]] <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan position and the output payload.
    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        placed_reg <= placed_next;
        pages_reg  <= pages_next;
        if (rd_en)
        begin
            vld_rd_reg <= in_map && map_vld_reg[frame_reg[MAP_AW-1:0]];
        end
        if (emit)
        begin
            out_page_reg  <= page_num_full[PAGE_NUM_W-1:0];
            out_frame_reg <= frame_reg[FRAME_IDX_W-1:0];
            out_last_reg  <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign page_number  = out_page_reg;
    assign frame_number = out_frame_reg;
    assign last         = out_last_reg;

endmodule

@@ rtl/page_frame_assigner.sv @@
// Top level of the page frame assigner: configuration registers, front part,
// command queue and back part. Depends on pfa_pkg, pfa_front, pfa_queue, pfa_back.
//
// A map word (kind 0) sets or clears the used bit of one frame. An allocate
// word (kind 1) first runs a serial divider that gives the page count,
// ceil(process_size / page_size) with page sizes below 128 taken as 128,
// capped at MAX_PAGES. The back part then walks the map from frame 3 upward,
// reading each frame through the map RAM's registered read and then checking
// it, handing each free frame to the next page; pages left over take frames
// 3 .. frame_count-1 in turn at one word per cycle while out_stall is low. A
// two-entry queue lets the front accept the next word while the back is still
// working. Allocations never change the map. Configuration is written through
// cfg_we, cfg_index and cfg_data: index 0 is page_size, index 1 is frame_count.
module page_frame_assigner
    import pfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int MAX_PAGES  = MAX_PAGES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [FRAME_IDX_W-1:0] frame_index,
    input  logic                   frame_used,
    input  logic [PROC_SIZE_W-1:0] process_size,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PAGE_NUM_W-1:0]  page_number,
    output logic [FRAME_IDX_W-1:0] frame_number,
    output logic                   last
);

    localparam int PG_W = $clog2(MAX_PAGES + 1);
    localparam int Q_W  = PG_W + $bits(pfa_cmd_t);

    logic [PAGE_SIZE_W-1:0]   page_size_reg;
    logic [FRAME_COUNT_W-1:0] frame_count_reg;

    logic            push, q_full, q_pop, q_not_empty;
    pfa_cmd_t        push_cmd, pop_cmd;
    logic [PG_W-1:0] push_pages, pop_pages;
    logic [Q_W-1:0]  pop_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg   <= MIN_PAGE_SIZE;
            frame_count_reg <= FRAME_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAGE_SIZE:
                begin
                    page_size_reg <= cfg_data[PAGE_SIZE_W-1:0];
                end
                CFG_FRAME_COUNT:
                begin
                    frame_count_reg <= cfg_data[FRAME_COUNT_W-1:0];
                end
                default:
                begin
                    page_size_reg <= page_size_reg;
                end
            endcase
        end
    end

    pfa_front #(
        .MAX_PAGES (MAX_PAGES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .frame_index  (frame_index),
        .frame_used   (frame_used),
        .process_size (process_size),
        .page_size    (page_size_reg),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd),
        .push_pages   (push_pages)
    );

    pfa_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_pages, push_cmd}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty)
    );

    // Split the queued command back into its parts.
    assign pop_pages = pop_data[Q_W-1 -: PG_W];
    assign pop_cmd   = pfa_cmd_t'(pop_data[$bits(pfa_cmd_t)-1:0]);

    pfa_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_count  (frame_count_reg),
        .q_not_empty  (q_not_empty),
        .q_cmd        (pop_cmd),
        .q_pages      (pop_pages),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .page_number  (page_number),
        .frame_number (frame_number),
        .last         (last)
    );

endmodule
